// ----- hw/rtl/xor_run_image_decoder_macros.svh -----
// Assertion macros shared by the checker
`ifndef XOR_RUN_IMAGE_DECODER_MACROS_SVH
`define XOR_RUN_IMAGE_DECODER_MACROS_SVH

// property must hold at each clock edge outside reset
`define XRD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// signal keeps its value on the cycle after the condition holds
`define XRD_HOLD(label, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		((cond) |=> $stable(sig))) else $error(msg);

`endif

// ----- hw/rtl/xrid_pkg.sv -----
`timescale 1ns / 1ps
package xrid_pkg;
	localparam int MaxWidthDef  = 1024;
	localparam int RingDepthDef = 16;

	// one decoded command handed from front to back
	typedef enum logic [1:0] {
		JOB_RUN = 2'd0,
		JOB_LIT = 2'd1,
		JOB_NOP = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic        restart;
		logic [14:0] word;
		logic [7:0]  lit;
	} job_t;

	typedef enum logic [1:0] {
		PM_CMD  = 2'd0,
		PM_LOW  = 2'd1,
		PM_LIT  = 2'd2
	} parse_mode_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_RD   = 2'd1,
		BK_PIX  = 2'd2
	} back_state_t;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_RED    = 3'd2;
	localparam logic [2:0] REG_GREEN  = 3'd3;
	localparam logic [2:0] REG_BLUE   = 3'd4;

	localparam logic [7:0] CMD_FILL = 8'hF0;
	localparam logic [7:0] CMD_REPLAY = 8'hE0;
	localparam logic [7:0] CMD_LIT  = 8'h80;

	function automatic logic [3:0] pal_nib(logic [63:0] pal, logic [3:0] c);
		logic [5:0] sh;
		sh = {c[3:1], 3'b000} + (c[0] ? 6'd0 : 6'd4);
		return pal[sh +: 4];
	endfunction
endpackage

// ----- hw/rtl/xrid_ram.sv -----
`timescale 1ns / 1ps
module xrid_ram #(
	parameter int Width = 4,
	parameter int Depth = 4100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hw/rtl/xrid_front.sv -----
`timescale 1ns / 1ps
module xrid_front #(
	parameter int RingDepth = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	output logic           job_valid,
	input  logic           job_ready,
	output xrid_pkg::job_t job
);
	import xrid_pkg::*;
	localparam int RingBits = $clog2(RingDepth);

	parse_mode_t        mode_q;
	logic [6:0]         high_q;
	logic [6:0]         left_q;
	logic [RingBits-1:0] ptr_q;
	logic [14:0]        ring_q [RingDepth];
	logic [14:0]        word;

	assign in_ready  = job_ready;
	assign job_valid = in_valid;
	assign word      = {high_q, in_byte};

	// classify the byte
	always_comb begin
		job = '{kind: JOB_NOP, restart: 1'b0, word: 15'd0, lit: in_byte};
		unique case (mode_q)
			PM_LOW: begin
				job.kind = JOB_RUN;
				job.word = word;
			end
			PM_LIT: job.kind = JOB_LIT;
			default: begin
				job.restart = 1'b1;
				if (in_byte >= CMD_FILL) begin
					job.kind = JOB_RUN;
					job.word = 15'h7E10 + {7'd0, in_byte};
				end else if (in_byte >= CMD_REPLAY) begin
					job.kind = JOB_RUN;
					job.word = ring_q[in_byte[RingBits-1:0]];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= PM_CMD;
			high_q <= '0;
			left_q <= '0;
			ptr_q  <= '0;
			for (int i = 0; i < RingDepth; i++) ring_q[i] <= '0;
		end else if (in_valid && job_ready) begin
			unique case (mode_q)
				PM_LOW: begin
					ring_q[ptr_q] <= word;
					ptr_q  <= ptr_q + 1'b1;
					mode_q <= PM_CMD;
				end
				PM_LIT: begin
					left_q <= left_q - 7'd1;
					if (left_q == 7'd1) mode_q <= PM_CMD;
				end
				default: begin
					mode_q <= PM_CMD;
					if (in_byte < CMD_LIT) begin
						high_q <= in_byte[6:0];
						mode_q <= PM_LOW;
					end else if (in_byte < CMD_REPLAY) begin
						left_q <= 7'(in_byte - 8'h7F);
						mode_q <= PM_LIT;
					end
				end
			endcase
		end
	end
endmodule

// ----- hw/rtl/xrid_queue.sv -----
`timescale 1ns / 1ps
module xrid_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  xrid_pkg::job_t wr_job,
	output logic           rd_valid,
	input  logic           rd_ready,
	output xrid_pkg::job_t rd_job
);
	import xrid_pkg::*;
	job_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = slot_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= wr_job;
	end

	// two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ----- hw/rtl/xrid_back.sv -----
`timescale 1ns / 1ps
module xrid_back #(
	parameter int MaxWidth = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  xrid_pkg::job_t job,
	input  logic [10:0]    width_cfg,
	input  logic [15:0]    height_cfg,
	input  logic [63:0]    pal_r,
	input  logic [63:0]    pal_g,
	input  logic [63:0]    pal_b,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    out_data,
	output logic [1:0]     out_count,
	output logic           out_last,
	output logic           out_done
);
	import xrid_pkg::*;
	localparam int HistDepth = 4 * MaxWidth + 4;
	localparam int HB = $clog2(HistDepth);
	localparam int WB = $clog2(MaxWidth + 1);

	back_state_t  st_q, st_d;
	logic [25:0]  pos_q;
	logic [25:0]  total_q;
	logic [WB-1:0] w_eff;
	logic [15:0]  h_eff;
	logic [14:0]  w_q;
	logic         lit_q;
	logic [7:0]   litb_q;
	logic [7:0]   left_q;
	logic [3:0]   p0_q;
	logic         have0_q;
	logic [25:0]  off_q;
	logic [2:0]   dc, dr;
	logic [25:0]  off_d;
	logic [HB-1:0] wptr_q, rd_addr, off_h;
	logic [3:0]   rdata, pix;
	logic         ob_full_q;
	logic         ob_load;
	logic         pend;
	logic         last_pix;
	logic         keep;
	logic [25:0]  pos_n;
	logic         done_now;

	// effective frame geometry
	always_comb begin
		w_eff = (width_cfg == 11'd0) ? WB'(1) :
			(32'(width_cfg) > MaxWidth) ? WB'(MaxWidth) : WB'(width_cfg);
		h_eff = (height_cfg == 16'd0) ? 16'd1 : height_cfg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) total_q <= 26'd1;
		else total_q <= 26'(w_eff) * 26'(h_eff);
	end

	// offset of the referenced pixel for an incoming run word
	always_comb begin
		dc = (job.word[5:4] == 2'd3) ? 3'd4 : {1'b0, job.word[5:4]};
		dr = (job.word[7:6] == 2'd3) ? 3'd4 : {1'b0, job.word[7:6]};
		off_d = 26'(dc) + 26'(dr) * 26'(w_eff);
	end

	xrid_ram #(.Width(4), .Depth(HistDepth)) u_hist (
		.clk  (clk),
		.we   (st_q == BK_PIX && pend && keep),
		.waddr(wptr_q),
		.wdata(pix),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// pixel for the current step, high nibble of a literal first
	always_comb begin
		if (lit_q) pix = left_q[0] ? litb_q[3:0] : litb_q[7:4];
		else if (off_q == 26'd0 || off_q > pos_q) pix = w_q[3:0];
		else pix = w_q[3:0] ^ rdata;
	end

	assign pend     = !ob_full_q || out_ready;
	assign keep     = pos_q < total_q;
	assign last_pix = (left_q == 8'd1);
	assign pos_n    = pos_q + 26'd1;
	assign done_now = keep && (pos_n == total_q);
	assign job_ready = (st_q == BK_IDLE);
	assign ob_load  = (st_q == BK_PIX) && pend &&
		((keep && (have0_q || last_pix || done_now)) || (!keep && last_pix && have0_q));

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (job_valid && job.kind != JOB_NOP) st_d = BK_RD;
			BK_RD:   st_d = BK_PIX;
			BK_PIX:  if (pend) st_d = last_pix ? BK_IDLE : BK_RD;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= BK_IDLE;
			pos_q     <= '0;
			wptr_q    <= '0;
			have0_q   <= 1'b0;
			ob_full_q <= 1'b0;
		end else begin
			st_q      <= st_d;
			ob_full_q <= ob_load || (ob_full_q && !out_ready);
			if (st_q == BK_IDLE && job_valid) begin
				have0_q <= 1'b0;
				if (job.restart && !(pos_q < total_q)) begin
					pos_q  <= '0;
					wptr_q <= '0;
				end
			end
			if (st_q == BK_PIX && pend) begin
				if (keep) begin
					pos_q   <= pos_n;
					wptr_q  <= (wptr_q == HB'(HistDepth - 1)) ? '0 : wptr_q + 1'b1;
					have0_q <= !(have0_q || last_pix || done_now);
				end else if (last_pix) begin
					have0_q <= 1'b0;
				end
			end
		end
	end

	// payload and output register
	always_ff @(posedge clk) begin
		if (st_q == BK_IDLE && job_valid) begin
			lit_q  <= (job.kind == JOB_LIT);
			litb_q <= job.lit;
			w_q    <= job.word;
			left_q <= (job.kind == JOB_LIT) ? 8'd2 : {1'b0, job.word[14:8]} + 8'd1;
			off_q  <= off_d;
		end else if (st_q == BK_PIX && pend) begin
			left_q <= left_q - 8'd1;
		end
		if (st_q == BK_PIX && pend && keep) begin
			if (have0_q) begin
				out_data  <= {pal_nib(pal_b, pix), pal_nib(pal_g, pix), pal_nib(pal_r, pix),
					pal_nib(pal_b, p0_q), pal_nib(pal_g, p0_q), pal_nib(pal_r, p0_q),
					pix, p0_q};
				out_count <= 2'd2;
				out_last  <= last_pix || done_now;
				out_done  <= done_now;
			end else if (last_pix || done_now) begin
				out_data  <= {12'd0, pal_nib(pal_b, pix), pal_nib(pal_g, pix),
					pal_nib(pal_r, pix), 4'd0, pix};
				out_count <= 2'd1;
				out_last  <= 1'b1;
				out_done  <= done_now;
			end else begin
				p0_q <= pix;
			end
		end else if (st_q == BK_PIX && pend && last_pix && have0_q) begin
			out_data  <= {12'd0, pal_nib(pal_b, p0_q), pal_nib(pal_g, p0_q),
				pal_nib(pal_r, p0_q), 4'd0, p0_q};
			out_count <= 2'd1;
			out_last  <= 1'b1;
			out_done  <= 1'b0;
		end
	end

	// read address for the next pixel, registered by the history RAM ahead of its use
	assign off_h   = (off_q >= 26'(HistDepth)) ? '0 : HB'(off_q);
	assign rd_addr = (wptr_q >= off_h) ? (wptr_q - off_h) :
		(wptr_q + HB'(HistDepth) - off_h);

	assign out_valid = ob_full_q;
endmodule

// ----- hw/rtl/xor_run_image_decoder.sv -----
`timescale 1ns / 1ps
// channel | dir | payload
// s_axis  | in  | tdata[7:0] code_byte
// m_axis  | out | tdata 33 bits in 40, tuser pixel_count, tlast last_of_run
// apb     | in  | 5 registers, 8-byte stride
// Each pixel is a history read (BK_RD), then a write and emit (BK_PIX), in the back end.
// A job is loaded in BK_IDLE before its pixels follow; a literal byte yields two pixels.
// A command byte without pixels is taken in BK_IDLE, and the back end stays there.
// Reset clears the parser, ring and frame position; history needs no clear.
// A held result stalls the back end; the two-entry job queue then fills and drops tready.
module xor_run_image_decoder #(
	parameter int MaxWidth  = xrid_pkg::MaxWidthDef,
	parameter int RingDepth = xrid_pkg::RingDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // code_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// first_index, second_index, first r g b, second r g b, frame_done, pad
	output logic [39:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // pixel_count
	output logic        m_axis_tlast,  // last_of_run
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import xrid_pkg::*;
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [63:0] red_q, green_q, blue_q;
	logic        fj_valid, fj_ready, bj_valid, bj_ready;
	job_t        fj, bj;
	logic [31:0] bd;
	logic        bdone;
	logic [2:0]  ridx;

	assign pready = 1'b1;
	assign ridx   = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd1; height_q <= 16'd1;
			red_q <= '0; green_q <= '0; blue_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[15:0];
				REG_RED:    red_q    <= pwdata;
				REG_GREEN:  green_q  <= pwdata;
				REG_BLUE:   blue_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_WIDTH:  prdata = {53'd0, width_q};
			REG_HEIGHT: prdata = {48'd0, height_q};
			REG_RED:    prdata = red_q;
			REG_GREEN:  prdata = green_q;
			REG_BLUE:   prdata = blue_q;
			default:    prdata = '0;
		endcase
	end

	xrid_front #(.RingDepth(RingDepth)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_byte(s_axis_tdata), .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	xrid_queue u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
	);

	xrid_back #(.MaxWidth(MaxWidth)) u_back (
		.clk, .arst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
		.width_cfg(width_q), .height_cfg(height_q), .pal_r(red_q), .pal_g(green_q),
		.pal_b(blue_q), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(bd), .out_count(m_axis_tuser), .out_last(m_axis_tlast), .out_done(bdone)
	);

	assign m_axis_tdata = {7'd0, bdone, bd};
endmodule

// ----- hw/rtl/xrid_checker.sv -----
`timescale 1ns / 1ps
`include "xor_run_image_decoder_macros.svh"
module xrid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast,
	input logic        pready
);
	`XRD_ASSERT(a_count, !m_axis_tvalid || m_axis_tuser == 2'd1 || m_axis_tuser == 2'd2, "bad count")
	`XRD_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "valid dropped")
	`XRD_HOLD(a_data_hold, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "data changed")
	`XRD_HOLD(a_last_hold, m_axis_tvalid && !m_axis_tready, m_axis_tlast, "last changed")
	`XRD_ASSERT(a_pready, pready, "pready low")
endmodule

bind xor_run_image_decoder xrid_checker u_chk (.*);

// ----- tb/xor_run_image_decoder_tb.sv -----
`timescale 1ns / 1ps
module xor_run_image_decoder_tb;
	import xrid_pkg::*;

	localparam int HistDepth = 4 * MaxWidthDef + 4;
	localparam int StallLimit = 4000;

	typedef struct {
		logic [3:0] idx_a, idx_b;
		logic [3:0] red_a, green_a, blue_a;
		logic [3:0] red_b, green_b, blue_b;
		logic [1:0] count;
		logic       last;
		logic       done;
	} pixel_pair_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	xor_run_image_decoder u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// code bytes waiting to be sent, decoded pixels waiting to be seen
	logic [7:0]  code_queue[$];
	pixel_pair_t pixel_queue[$];
	int          errors;
	int          bytes_sent;
	bit          sender_pause;
	bit          hold_go;

	// shadow registers and decoder state
	logic [10:0] sh_width;
	logic [15:0] sh_height;
	logic [63:0] sh_red, sh_green, sh_blue;
	parse_mode_t mode;
	logic [6:0]  high_bits;
	logic [6:0]  lit_left;
	logic [14:0] ring[RingDepthDef];
	logic [3:0]  ring_ptr;
	int unsigned frame_pos;
	logic [3:0]  history[HistDepth];
	logic [3:0]  new_pix[$];
	bit          frame_hit;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned cols();
		int unsigned w;
		w = sh_width;
		if (w == 0) w = 1;
		if (w > MaxWidthDef) w = MaxWidthDef;
		return w;
	endfunction

	function automatic longint unsigned pixels_per_frame();
		longint unsigned h;
		h = sh_height;
		if (h == 0) h = 1;
		return longint'(cols()) * h;
	endfunction

	function automatic logic [3:0] color_of(logic [63:0] pal, logic [3:0] c);
		int sh;
		sh = 8 * c[3:1] + (c[0] ? 0 : 4);
		return pal[sh +: 4];
	endfunction

	function automatic void store_pixel(logic [3:0] v);
		if (longint'(frame_pos) >= pixels_per_frame()) return;
		history[frame_pos % HistDepth] = v;
		frame_pos++;
		new_pix.push_back(v);
		if (longint'(frame_pos) == pixels_per_frame()) frame_hit = 1;
	endfunction

	function automatic void play_run(logic [14:0] word);
		int unsigned n, reach, k;
		int unsigned steps[4];
		logic [3:0] sel, ref_pix;
		steps = '{0, 1, 2, 4};
		n = word[14:8] + 1;
		sel = word[7:4];
		reach = steps[sel[1:0]] + steps[sel[3:2]] * cols();
		for (k = 0; k < n; k++) begin
			ref_pix = (reach == 0 || reach > frame_pos) ? 4'd0
				: history[(frame_pos - reach) % HistDepth];
			store_pixel(word[3:0] ^ ref_pix);
		end
	endfunction

	// decode one accepted code byte, queue the pixel pairs it yields
	function automatic void decode_byte(logic [7:0] b);
		int npairs, k;
		pixel_pair_t p;
		new_pix.delete();
		frame_hit = 0;
		if (mode == PM_LOW) begin
			ring[ring_ptr] = {high_bits, b};
			ring_ptr++;
			mode = PM_CMD;
			play_run({high_bits, b});
		end else if (mode == PM_LIT) begin
			store_pixel(b[7:4]);
			store_pixel(b[3:0]);
			lit_left--;
			if (lit_left == 0) mode = PM_CMD;
		end else begin
			mode = PM_CMD;
			if (longint'(frame_pos) >= pixels_per_frame()) frame_pos = 0;
			if (b >= CMD_FILL) play_run(15'h7E10 + 15'(b));
			else if (b >= CMD_REPLAY) play_run(ring[b[3:0]]);
			else if (b >= CMD_LIT) begin
				lit_left = 7'(b - 8'h7F);
				mode = PM_LIT;
			end else begin
				high_bits = b[6:0];
				mode = PM_LOW;
			end
		end
		npairs = (new_pix.size() + 1) / 2;
		for (k = 0; k < npairs; k++) begin
			p.idx_a = new_pix[2 * k];
			p.count = (2 * k + 1 < new_pix.size()) ? 2'd2 : 2'd1;
			p.idx_b = (p.count == 2) ? new_pix[2 * k + 1] : 4'd0;
			p.red_a = color_of(sh_red, p.idx_a);
			p.green_a = color_of(sh_green, p.idx_a);
			p.blue_a = color_of(sh_blue, p.idx_a);
			p.red_b = (p.count == 2) ? color_of(sh_red, p.idx_b) : 4'd0;
			p.green_b = (p.count == 2) ? color_of(sh_green, p.idx_b) : 4'd0;
			p.blue_b = (p.count == 2) ? color_of(sh_blue, p.idx_b) : 4'd0;
			p.last = (k + 1 == npairs);
			p.done = p.last && frame_hit;
			pixel_queue.push_back(p);
		end
	endfunction

	// sender: bursts of random length with random gaps
	int burst_left, gap_left;
	bit just_taken;
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
		end else if (!s_axis_tvalid || just_taken) begin
			if (gap_left > 0 || sender_pause || code_queue.size() == 0) begin
				if (gap_left > 0) gap_left--;
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= code_queue[0];
				if (burst_left > 0) burst_left--;
				else begin
					burst_left = $urandom_range(0, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// receiver: own stall pattern, plus one long hold-off
	int hold_cnt, stall_mode_cnt;
	bit hold_done, stall_heavy;
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (hold_go && !hold_done) begin
				hold_cnt = 600;
				hold_done = 1;
			end
			if (stall_mode_cnt == 0) begin
				stall_mode_cnt = $urandom_range(10, 80);
				stall_heavy = ($urandom_range(0, 2) != 0);
			end else stall_mode_cnt--;
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else m_axis_tready <= stall_heavy ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	task automatic chk(string name, logic [3:0] exp_v, logic [3:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// accept bytes into the predictor, check pixel transfers
	int idle_cycles;
	always @(posedge clk) begin
		pixel_pair_t e;
		just_taken = 0;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata);
				void'(code_queue.pop_front());
				bytes_sent++;
				just_taken = 1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pixel_queue.size() == 0) begin
					$display("%0t: unexpected transfer, actual %h", $time, m_axis_tdata);
					errors++;
				end else begin
					e = pixel_queue.pop_front();
					chk("first_index", e.idx_a, m_axis_tdata[3:0]);
					chk("second_index", e.idx_b, m_axis_tdata[7:4]);
					chk("first_red", e.red_a, m_axis_tdata[11:8]);
					chk("first_green", e.green_a, m_axis_tdata[15:12]);
					chk("first_blue", e.blue_a, m_axis_tdata[19:16]);
					chk("second_red", e.red_b, m_axis_tdata[23:20]);
					chk("second_green", e.green_b, m_axis_tdata[27:24]);
					chk("second_blue", e.blue_b, m_axis_tdata[31:28]);
					chk("frame_done", 4'(e.done), 4'(m_axis_tdata[32]));
					chk("pixel_count", 4'(e.count), 4'(m_axis_tuser));
					chk("last_of_run", 4'(e.last), 4'(m_axis_tlast));
				end
			end
		end
	end

	// watchdog: no transfer for too long while work is pending
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (code_queue.size() == 0 && pixel_queue.size() == 0))
			idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= StallLimit) begin
			$display("%0t: timeout, %0d results outstanding", $time, pixel_queue.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WIDTH: sh_width = value[10:0];
			REG_HEIGHT: sh_height = value[15:0];
			REG_RED: sh_red = value;
			REG_GREEN: sh_green = value;
			REG_BLUE: sh_blue = value;
			default: ;
		endcase
	endtask

	task automatic set_frame(logic [10:0] w, logic [15:0] h, logic [63:0] r,
			logic [63:0] g, logic [63:0] b);
		reg_write(REG_WIDTH, {53'd0, w});
		reg_write(REG_HEIGHT, {48'd0, h});
		reg_write(REG_RED, r);
		reg_write(REG_GREEN, g);
		reg_write(REG_BLUE, b);
	endtask

	task automatic wait_drained(bit settle);
		while (code_queue.size() != 0 || pixel_queue.size() != 0) @(posedge clk);
		if (settle) repeat (400) @(posedge clk);
	endtask

	// one well-formed command with random content, or a stray byte
	task automatic push_command();
		int pick, n, k;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			code_queue.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127))
				: 8'($urandom_range(0, 7)));
			code_queue.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 50) code_queue.push_back(CMD_REPLAY | 8'($urandom_range(0, 15)));
		else if (pick < 58) code_queue.push_back(CMD_FILL | 8'($urandom_range(0, 15)));
		else if (pick < 90) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 96) : $urandom_range(1, 4);
			code_queue.push_back(8'(8'h7F + n));
			for (k = 0; k < n; k++) code_queue.push_back(8'($urandom_range(0, 255)));
		end else code_queue.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic random_phase(int n_bytes);
		int target;
		target = bytes_sent + code_queue.size() + n_bytes;
		while (bytes_sent + code_queue.size() < target) push_command();
	endtask

	function automatic logic [63:0] rand64();
		return {32'($urandom), 32'($urandom)};
	endfunction

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		errors = 0;
		bytes_sent = 0;
		sender_pause = 0;
		hold_go = 0;
		sh_width = 11'd1;
		sh_height = 16'd1;
		sh_red = '0;
		sh_green = '0;
		sh_blue = '0;
		mode = PM_CMD;
		high_bits = '0;
		lit_left = '0;
		ring_ptr = '0;
		frame_pos = 0;
		foreach (ring[i]) ring[i] = '0;
		foreach (history[i]) history[i] = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: small frame, every command and field extreme
		set_frame(11'd4, 16'd3, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, rand64());
		code_queue = '{8'h00, 8'h00, 8'h7F, 8'hFF, 8'hE0, 8'hEF, 8'hE1, 8'hF0, 8'hFF,
			8'h80, 8'hA5, 8'h81, 8'h12, 8'h34, 8'h03, 8'h5A, 8'h01, 8'hC7,
			8'hF5, 8'h82, 8'hFF, 8'h00, 8'h0F, 8'h40, 8'hEE};
		wait_drained(1);

		// width and height of zero act as one
		set_frame(11'd0, 16'd0, '1, '0, rand64());
		random_phase(40);
		wait_drained(1);

		// oversize width, long receiver hold-off fills the block
		set_frame(11'h7FF, 16'd2, rand64(), rand64(), '1);
		hold_go = 1;
		random_phase(60);
		wait_drained(1);

		// largest legal frame, sender pauses halfway until every result is in
		set_frame(11'd1024, 16'hFFFF, '0, rand64(), '0);
		random_phase(40);
		while (code_queue.size() > 20) @(posedge clk);
		sender_pause = 1;
		while (pixel_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		sender_pause = 0;
		wait_drained(0);
		random_phase(40);
		wait_drained(1);

		// small frames that end and restart often
		repeat (4) begin
			set_frame(11'($urandom_range(1, 9)), 16'($urandom_range(1, 7)),
				rand64(), rand64(), rand64());
			random_phase(45);
			wait_drained(1);
		end

		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/xrid_pkg.sv
hw/rtl/xrid_ram.sv
hw/rtl/xrid_front.sv
hw/rtl/xrid_queue.sv
hw/rtl/xrid_back.sv
hw/rtl/xor_run_image_decoder.sv
hw/rtl/xrid_checker.sv
tb/xor_run_image_decoder_tb.sv
